// ===== rtl/core/plt_pkg.sv =====
// Shared constants, codes and control types of the positional list table.
package plt_pkg;

   localparam int DEPTH   = 16;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int FUNC_W  = 3;
   localparam int POS_W   = 5;
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 4;
   localparam int ENTRY_W = 5;
   localparam int PTR_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   typedef enum logic [FUNC_W-1:0] {
      FN_INSERT  = 3'd0,
      FN_READ    = 3'd1,
      FN_REPLACE = 3'd2,
      FN_REMOVE  = 3'd3,
      FN_SORTED  = 3'd4,
      FN_SEARCH  = 3'd5,
      FN_REVERSE = 3'd6
   } plt_func_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_UP_PRIME,
      S_UP,
      S_PUT,
      S_RD_WAIT,
      S_DN_PRIME,
      S_DN,
      S_SCAN_PRIME,
      S_SCAN,
      S_REV_RI,
      S_REV_RJ,
      S_REV_WI,
      S_REV_WJ,
      S_DONE
   } plt_state_type;

   typedef enum logic [2:0] {
      RS_POS,
      RS_CUR,
      RS_CUR_M1,
      RS_CUR_M2,
      RS_CUR_P1,
      RS_CUR_P2,
      RS_HI
   } plt_rsel_type;

   typedef enum logic [1:0] {
      WS_POS,
      WS_CUR,
      WS_HI
   } plt_wsel_type;

   typedef enum logic [1:0] {
      DS_VAL,
      DS_RDATA,
      DS_HOLD
   } plt_dsel_type;

   typedef enum logic [2:0] {
      CO_HOLD,
      CO_ZERO,
      CO_COUNT,
      CO_POS,
      CO_INC,
      CO_DEC
   } plt_cur_op_type;

   typedef struct packed {
      logic           load;
      plt_rsel_type   rd_sel;
      logic           wr_en;
      plt_wsel_type   wr_sel;
      plt_dsel_type   wd_sel;
      plt_cur_op_type cur_op;
      logic           hi_init;
      logic           hi_dec;
      logic           hold_ld;
      logic           cnt_inc;
      logic           cnt_dec;
      logic           set_ok;
      logic           rd_ld;
      logic           mark_hit;
      logic           mark_end;
   } plt_cmd_type;

   typedef struct packed {
      plt_func_type func;
      logic         ins_ok;
      logic         in_range;
      logic         pos_eq_cnt;
      logic         pos_last;
      logic         not_full;
      logic         empty;
      logic         multi;
      logic         up_last;
      logic         dn_last;
      logic         scan_hit;
      logic         scan_end;
      logic         rev_more;
   } plt_status_type;

endpackage

// ===== rtl/core/positional_list_table.sv =====
// Top level of the positional list table: controller, datapath and checks.
//
//   channel   ports                                          handshake
//   --------  ---------------------------------------------  -----------------------------
//   request   req_func, req_position, req_value              taken when start && !busy
//   result    rsp_ok, rsp_read_value, rsp_found_index,       shown one cycle, rsp_strobe
//             rsp_entry_count
//
// What each item does with the entry RAM between its start and its strobed result:
//   read, replace, an undefined code and any rejected item walk no entries;
//   remove shifts the entries above the position down (none for the last entry),
//   insert shifts the entries from the position up (none when appending),
//   search scans from the front to a hit or the end, sorted insert scans to the first
//   entry not below the value and inserts there, reverse swaps pairs from both ends.
//   One RAM read and write per cycle; each shift and scan walks one entry a cycle.
// A new item may start in the cycle its predecessor's result is strobed.
// Reset clears the fill count and the controller; entry contents need no clearing.
// The receiver cannot stall: each result is strobed once and not held.
module positional_list_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [plt_pkg::FUNC_W-1:0]           req_func,
   input  logic [plt_pkg::POS_W-1:0]            req_position,
   input  logic signed [plt_pkg::VALUE_W-1:0]   req_value,
   output logic                                rsp_strobe,
   output logic                                rsp_ok,
   output logic signed [plt_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic [plt_pkg::INDEX_W-1:0]          rsp_found_index,
   output logic [plt_pkg::ENTRY_W-1:0]          rsp_entry_count
);

   plt_pkg::plt_cmd_type    cmd;
   plt_pkg::plt_status_type stat;

   // Sequence each item: decode, then walk the entries as the function needs.
   plt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy),
      .strobe (rsp_strobe)
   );

   // Hold the entries, the fill count and the result fields.
   plt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_func        (req_func),
      .req_position    (req_position),
      .req_value       (req_value),
      .stat            (stat),
      .rsp_ok          (rsp_ok),
      .rsp_read_value  (rsp_read_value),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count)
   );

   // Grow the table only while it has room.
   a_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> stat.not_full)
      else $error("fill count raised on a full table");

   // Shrink the table only while it holds entries.
   a_dec_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_dec |-> !stat.empty)
      else $error("fill count lowered on an empty table");

   // Never write the entry RAM in the cycle a new item is taken.
   a_no_write_on_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.wr_en)
      else $error("entry write while taking a new item");

   // Each item yields one strobed result, never two in a row.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

endmodule

// ===== rtl/core/plt_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered data.
module plt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/plt_ctrl.sv =====
// Controller state machine that sequences each request over the datapath.
module plt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  plt_pkg::plt_status_type stat,
   output plt_pkg::plt_cmd_type    cmd,
   output logic                   busy,
   output logic                   strobe
);

   plt_pkg::plt_state_type state_ff;
   plt_pkg::plt_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.rd_sel   = plt_pkg::RS_CUR;
      cmd.wr_sel   = plt_pkg::WS_POS;
      cmd.wd_sel   = plt_pkg::DS_VAL;
      cmd.cur_op   = plt_pkg::CO_HOLD;

      case (state_ff)
         plt_pkg::S_IDLE, plt_pkg::S_DONE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = plt_pkg::S_DISPATCH;
            end else begin
               state_in = plt_pkg::S_IDLE;
            end
         end

         plt_pkg::S_DISPATCH: begin
            state_in = plt_pkg::S_DONE;
            case (stat.func)
               plt_pkg::FN_INSERT: begin
                  if (stat.ins_ok) begin
                     if (stat.pos_eq_cnt) begin
                        state_in = plt_pkg::S_PUT;
                     end else begin
                        cmd.cur_op = plt_pkg::CO_COUNT;
                        state_in   = plt_pkg::S_UP_PRIME;
                     end
                  end
               end
               plt_pkg::FN_READ: begin
                  if (stat.in_range) begin
                     cmd.rd_sel = plt_pkg::RS_POS;
                     state_in   = plt_pkg::S_RD_WAIT;
                  end
               end
               plt_pkg::FN_REPLACE: begin
                  if (stat.in_range) begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = plt_pkg::WS_POS;
                     cmd.wd_sel = plt_pkg::DS_VAL;
                     cmd.set_ok = 1'b1;
                  end
               end
               plt_pkg::FN_REMOVE: begin
                  if (stat.in_range) begin
                     if (stat.pos_last) begin
                        cmd.cnt_dec = 1'b1;
                        cmd.set_ok  = 1'b1;
                     end else begin
                        cmd.cur_op = plt_pkg::CO_POS;
                        state_in   = plt_pkg::S_DN_PRIME;
                     end
                  end
               end
               plt_pkg::FN_SORTED: begin
                  if (stat.not_full) begin
                     if (stat.empty) begin
                        cmd.mark_end = 1'b1;
                        state_in     = plt_pkg::S_PUT;
                     end else begin
                        cmd.cur_op = plt_pkg::CO_ZERO;
                        state_in   = plt_pkg::S_SCAN_PRIME;
                     end
                  end
               end
               plt_pkg::FN_SEARCH: begin
                  if (!stat.empty) begin
                     cmd.cur_op = plt_pkg::CO_ZERO;
                     state_in   = plt_pkg::S_SCAN_PRIME;
                  end
               end
               plt_pkg::FN_REVERSE: begin
                  cmd.set_ok = 1'b1;
                  if (stat.multi) begin
                     cmd.cur_op  = plt_pkg::CO_ZERO;
                     cmd.hi_init = 1'b1;
                     state_in    = plt_pkg::S_REV_RI;
                  end
               end
               default: begin
                  state_in = plt_pkg::S_DONE;
               end
            endcase
         end

         plt_pkg::S_UP_PRIME: begin
            cmd.rd_sel = plt_pkg::RS_CUR_M1;
            state_in   = plt_pkg::S_UP;
         end

         plt_pkg::S_UP: begin
            cmd.rd_sel = plt_pkg::RS_CUR_M2;
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = plt_pkg::WS_CUR;
            cmd.wd_sel = plt_pkg::DS_RDATA;
            cmd.cur_op = plt_pkg::CO_DEC;
            if (stat.up_last) begin
               state_in = plt_pkg::S_PUT;
            end
         end

         plt_pkg::S_PUT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = plt_pkg::WS_POS;
            cmd.wd_sel  = plt_pkg::DS_VAL;
            cmd.cnt_inc = 1'b1;
            cmd.set_ok  = 1'b1;
            state_in    = plt_pkg::S_DONE;
         end

         plt_pkg::S_RD_WAIT: begin
            cmd.rd_ld  = 1'b1;
            cmd.set_ok = 1'b1;
            state_in   = plt_pkg::S_DONE;
         end

         plt_pkg::S_DN_PRIME: begin
            cmd.rd_sel = plt_pkg::RS_CUR_P1;
            state_in   = plt_pkg::S_DN;
         end

         plt_pkg::S_DN: begin
            cmd.rd_sel = plt_pkg::RS_CUR_P2;
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = plt_pkg::WS_CUR;
            cmd.wd_sel = plt_pkg::DS_RDATA;
            cmd.cur_op = plt_pkg::CO_INC;
            if (stat.dn_last) begin
               cmd.cnt_dec = 1'b1;
               cmd.set_ok  = 1'b1;
               state_in    = plt_pkg::S_DONE;
            end
         end

         plt_pkg::S_SCAN_PRIME: begin
            cmd.rd_sel = plt_pkg::RS_CUR;
            cmd.cur_op = plt_pkg::CO_INC;
            state_in   = plt_pkg::S_SCAN;
         end

         plt_pkg::S_SCAN: begin
            cmd.rd_sel = plt_pkg::RS_CUR;
            cmd.cur_op = plt_pkg::CO_INC;
            if (stat.scan_hit) begin
               cmd.mark_hit = 1'b1;
               if (stat.func == plt_pkg::FN_SEARCH) begin
                  cmd.set_ok = 1'b1;
                  state_in   = plt_pkg::S_DONE;
               end else begin
                  cmd.cur_op = plt_pkg::CO_COUNT;
                  state_in   = plt_pkg::S_UP_PRIME;
               end
            end else if (stat.scan_end) begin
               if (stat.func == plt_pkg::FN_SEARCH) begin
                  state_in = plt_pkg::S_DONE;
               end else begin
                  cmd.mark_end = 1'b1;
                  state_in     = plt_pkg::S_PUT;
               end
            end
         end

         plt_pkg::S_REV_RI: begin
            cmd.rd_sel = plt_pkg::RS_CUR;
            state_in   = plt_pkg::S_REV_RJ;
         end

         plt_pkg::S_REV_RJ: begin
            cmd.rd_sel  = plt_pkg::RS_HI;
            cmd.hold_ld = 1'b1;
            state_in    = plt_pkg::S_REV_WI;
         end

         plt_pkg::S_REV_WI: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = plt_pkg::WS_CUR;
            cmd.wd_sel = plt_pkg::DS_RDATA;
            state_in   = plt_pkg::S_REV_WJ;
         end

         plt_pkg::S_REV_WJ: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = plt_pkg::WS_HI;
            cmd.wd_sel = plt_pkg::DS_HOLD;
            cmd.rd_sel = plt_pkg::RS_CUR_P1;
            cmd.cur_op = plt_pkg::CO_INC;
            cmd.hi_dec = 1'b1;
            if (stat.rev_more) begin
               state_in = plt_pkg::S_REV_RJ;
            end else begin
               state_in = plt_pkg::S_DONE;
            end
         end

         default: begin
            state_in = plt_pkg::S_IDLE;
         end
      endcase
   end

   assign busy   = (state_ff != plt_pkg::S_IDLE) && (state_ff != plt_pkg::S_DONE);
   assign strobe = (state_ff == plt_pkg::S_DONE);

endmodule

// ===== rtl/core/plt_dp.sv =====
// Datapath: entry RAM, fill count, cursors, request and result registers.
module plt_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  plt_pkg::plt_cmd_type                 cmd,
   input  logic [plt_pkg::FUNC_W-1:0]           req_func,
   input  logic [plt_pkg::POS_W-1:0]            req_position,
   input  logic signed [plt_pkg::VALUE_W-1:0]   req_value,
   output plt_pkg::plt_status_type              stat,
   output logic                                rsp_ok,
   output logic signed [plt_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic [plt_pkg::INDEX_W-1:0]          rsp_found_index,
   output logic [plt_pkg::ENTRY_W-1:0]          rsp_entry_count
);

   plt_pkg::plt_func_type            func_ff;
   logic [plt_pkg::PTR_W-1:0]        pos_ff,   pos_in;
   logic [plt_pkg::VALUE_W-1:0]      val_ff;
   logic [plt_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [plt_pkg::CNT_W-1:0]        cur_ff,   cur_in;
   logic [plt_pkg::ADDR_W-1:0]       hi_ff,    hi_in;
   logic [plt_pkg::VALUE_W-1:0]      hold_ff;
   logic                             ok_ff,    ok_in;
   logic [plt_pkg::VALUE_W-1:0]      rdv_ff,   rdv_in;
   logic [plt_pkg::INDEX_W-1:0]      idx_ff,   idx_in;

   logic [plt_pkg::CNT_W-1:0]        cur_m1;
   logic [plt_pkg::CNT_W:0]          cur_x;
   logic [plt_pkg::CNT_W:0]          ra_wide;
   logic [plt_pkg::ADDR_W-1:0]       rd_addr;
   logic [plt_pkg::ADDR_W-1:0]       wr_addr;
   logic [plt_pkg::VALUE_W-1:0]      wr_data;
   logic [plt_pkg::VALUE_W-1:0]      rd_data;
   logic [plt_pkg::PTR_W-1:0]        cnt_ptr;
   logic [plt_pkg::PTR_W:0]          pos_p1;

   plt_ram #(
      .WIDTH (plt_pkg::VALUE_W),
      .DEPTH (plt_pkg::DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cur_m1  = cur_ff - 1'b1;
   assign cur_x   = {1'b0, cur_ff};
   assign cnt_ptr = plt_pkg::PTR_W'(count_ff);
   assign pos_p1  = (plt_pkg::PTR_W+1)'(pos_ff) + 1'b1;

   // Address and data selection for the RAM ports.
   always_comb begin
      case (cmd.rd_sel)
         plt_pkg::RS_POS:    ra_wide = (plt_pkg::CNT_W+1)'(pos_ff);
         plt_pkg::RS_CUR:    ra_wide = cur_x;
         plt_pkg::RS_CUR_M1: ra_wide = cur_x - (plt_pkg::CNT_W+1)'(1);
         plt_pkg::RS_CUR_M2: ra_wide = cur_x - (plt_pkg::CNT_W+1)'(2);
         plt_pkg::RS_CUR_P1: ra_wide = cur_x + (plt_pkg::CNT_W+1)'(1);
         plt_pkg::RS_CUR_P2: ra_wide = cur_x + (plt_pkg::CNT_W+1)'(2);
         plt_pkg::RS_HI:     ra_wide = (plt_pkg::CNT_W+1)'(hi_ff);
         default:            ra_wide = cur_x;
      endcase

      case (cmd.wr_sel)
         plt_pkg::WS_POS: wr_addr = plt_pkg::ADDR_W'(pos_ff);
         plt_pkg::WS_CUR: wr_addr = plt_pkg::ADDR_W'(cur_ff);
         plt_pkg::WS_HI:  wr_addr = hi_ff;
         default:         wr_addr = plt_pkg::ADDR_W'(pos_ff);
      endcase

      case (cmd.wd_sel)
         plt_pkg::DS_VAL:   wr_data = val_ff;
         plt_pkg::DS_RDATA: wr_data = rd_data;
         plt_pkg::DS_HOLD:  wr_data = hold_ff;
         default:           wr_data = val_ff;
      endcase
   end

   assign rd_addr = ra_wide[plt_pkg::ADDR_W-1:0];

   // Next-state logic of the registers.
   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      cur_in   = cur_ff;
      hi_in    = hi_ff;
      ok_in    = ok_ff;
      rdv_in   = rdv_ff;
      idx_in   = idx_ff;

      if (cmd.load) begin
         pos_in = plt_pkg::PTR_W'(req_position);
         ok_in  = 1'b0;
         rdv_in = '0;
         idx_in = '0;
      end
      if (cmd.mark_hit) begin
         pos_in = plt_pkg::PTR_W'(cur_m1);
         idx_in = plt_pkg::INDEX_W'(cur_m1);
      end
      if (cmd.mark_end) begin
         pos_in = cnt_ptr;
         idx_in = plt_pkg::INDEX_W'(count_ff);
      end
      if (cmd.set_ok) begin
         ok_in = 1'b1;
      end
      if (cmd.rd_ld) begin
         rdv_in = rd_data;
      end
      if (cmd.cnt_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - 1'b1;
      end

      case (cmd.cur_op)
         plt_pkg::CO_ZERO:  cur_in = '0;
         plt_pkg::CO_COUNT: cur_in = count_ff;
         plt_pkg::CO_POS:   cur_in = plt_pkg::CNT_W'(pos_ff);
         plt_pkg::CO_INC:   cur_in = cur_ff + 1'b1;
         plt_pkg::CO_DEC:   cur_in = cur_m1;
         default:           cur_in = cur_ff;
      endcase

      if (cmd.hi_init) begin
         hi_in = plt_pkg::ADDR_W'(count_ff - 1'b1);
      end else if (cmd.hi_dec) begin
         hi_in = hi_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= plt_pkg::plt_func_type'(req_func);
         val_ff  <= req_value;
      end
      if (cmd.hold_ld) begin
         hold_ff <= rd_data;
      end
      pos_ff <= pos_in;
      cur_ff <= cur_in;
      hi_ff  <= hi_in;
      ok_ff  <= ok_in;
      rdv_ff <= rdv_in;
      idx_ff <= idx_in;
   end

   // Status flags for the controller.
   always_comb begin
      stat            = '0;
      stat.func       = func_ff;
      stat.not_full   = count_ff < plt_pkg::DEPTH_CNT;
      stat.in_range   = pos_ff < cnt_ptr;
      stat.pos_eq_cnt = pos_ff == cnt_ptr;
      stat.ins_ok     = (pos_ff <= cnt_ptr) && (count_ff < plt_pkg::DEPTH_CNT);
      stat.pos_last   = pos_p1 == (plt_pkg::PTR_W+1)'(count_ff);
      stat.empty      = count_ff == '0;
      stat.multi      = count_ff > plt_pkg::CNT_W'(1);
      stat.up_last    = (plt_pkg::PTR_W+1)'(cur_ff) == pos_p1;
      stat.dn_last    = (cur_x + (plt_pkg::CNT_W+1)'(2)) == {1'b0, count_ff};
      stat.scan_end   = cur_ff == count_ff;
      stat.rev_more   = (cur_x + (plt_pkg::CNT_W+1)'(2)) < (plt_pkg::CNT_W+1)'(hi_ff);
      if (func_ff == plt_pkg::FN_SEARCH) begin
         stat.scan_hit = rd_data == val_ff;
      end else begin
         stat.scan_hit = $signed(rd_data) >= $signed(val_ff);
      end
   end

   assign rsp_ok          = ok_ff;
   assign rsp_read_value  = rdv_ff;
   assign rsp_found_index = idx_ff;
   assign rsp_entry_count = plt_pkg::ENTRY_W'(count_ff);

endmodule

// ===== test/list_table_checker.sv =====
// Result checker for the positional list table: shadow table, expected-result queue, compare.
`timescale 1ns / 100ps

module list_table_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [plt_pkg::FUNC_W-1:0]         req_func,
   input  logic [plt_pkg::POS_W-1:0]          req_position,
   input  logic signed [plt_pkg::VALUE_W-1:0] req_value,
   input  logic                               rsp_strobe,
   input  logic                               rsp_ok,
   input  logic signed [plt_pkg::VALUE_W-1:0] rsp_read_value,
   input  logic [plt_pkg::INDEX_W-1:0]        rsp_found_index,
   input  logic [plt_pkg::ENTRY_W-1:0]        rsp_entry_count,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 fill_level
);

   typedef struct packed {
      logic                               ok;
      logic signed [plt_pkg::VALUE_W-1:0] read_value;
      logic [plt_pkg::INDEX_W-1:0]        found_index;
      logic [plt_pkg::ENTRY_W-1:0]        entry_count;
   } table_result_type;

   logic signed [plt_pkg::VALUE_W-1:0] shadow_entries [plt_pkg::DEPTH];
   int                                 shadow_count;
   table_result_type                   expected_results [$];
   table_result_type                   want;

   // Move entries at and above the slot up one place and drop the value in.
   function automatic void open_gap(int slot, logic signed [plt_pkg::VALUE_W-1:0] value);
      for (int i = shadow_count; i > slot; i--)
         shadow_entries[i] = shadow_entries[i-1];
      shadow_entries[slot] = value;
      shadow_count++;
   endfunction

   function automatic table_result_type apply_request(
         logic [plt_pkg::FUNC_W-1:0] func,
         logic [plt_pkg::POS_W-1:0] position,
         logic signed [plt_pkg::VALUE_W-1:0] value);
      table_result_type                   r;
      int                                 slot;
      int                                 lo;
      int                                 hi;
      int                                 pos;
      logic signed [plt_pkg::VALUE_W-1:0] swap;
      r   = '0;
      pos = int'(position);
      case (func)
         plt_pkg::FN_INSERT: begin
            if (pos <= shadow_count && shadow_count < plt_pkg::DEPTH) begin
               open_gap(pos, value);
               r.ok = 1'b1;
            end
         end
         plt_pkg::FN_READ: begin
            if (pos < shadow_count) begin
               r.read_value = shadow_entries[pos];
               r.ok         = 1'b1;
            end
         end
         plt_pkg::FN_REPLACE: begin
            if (pos < shadow_count) begin
               shadow_entries[pos] = value;
               r.ok                = 1'b1;
            end
         end
         plt_pkg::FN_REMOVE: begin
            if (pos < shadow_count) begin
               for (int i = pos; i + 1 < shadow_count; i++)
                  shadow_entries[i] = shadow_entries[i+1];
               shadow_count--;
               r.ok = 1'b1;
            end
         end
         plt_pkg::FN_SORTED: begin
            if (shadow_count < plt_pkg::DEPTH) begin
               for (slot = 0; slot < shadow_count; slot++)
                  if (shadow_entries[slot] >= value)
                     break;
               open_gap(slot, value);
               r.found_index = plt_pkg::INDEX_W'(slot);
               r.ok          = 1'b1;
            end
         end
         plt_pkg::FN_SEARCH: begin
            for (slot = 0; slot < shadow_count; slot++) begin
               if (shadow_entries[slot] == value) begin
                  r.found_index = plt_pkg::INDEX_W'(slot);
                  r.ok          = 1'b1;
                  break;
               end
            end
         end
         plt_pkg::FN_REVERSE: begin
            lo = 0;
            hi = shadow_count - 1;
            while (lo < hi) begin
               swap               = shadow_entries[lo];
               shadow_entries[lo] = shadow_entries[hi];
               shadow_entries[hi] = swap;
               lo++;
               hi--;
            end
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.entry_count = plt_pkg::ENTRY_W'(shadow_count);
      return r;
   endfunction

   function automatic void check_field(string field, longint expected, longint actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", field, expected, actual);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         fail_count   = 0;
         expected_results.delete();
      end else begin
         // A result can share its edge with the next request, so retire first.
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               $error("rsp_strobe: expected no result, actual result with ok=%0d", rsp_ok);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("rsp_ok", want.ok, rsp_ok);
               check_field("rsp_read_value", want.read_value, rsp_read_value);
               check_field("rsp_found_index", want.found_index, rsp_found_index);
               check_field("rsp_entry_count", want.entry_count, rsp_entry_count);
            end
         end
         if (start && !busy)
            expected_results.push_back(apply_request(req_func, req_position, req_value));
      end
      pending    = expected_results.size();
      fill_level = shadow_count;
   end

endmodule

// ===== test/testbench.sv =====
// Testbench top for the positional list table: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;

   localparam int RANDOM_ITEMS   = 1625;
   localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles; well above the slowest item plus the longest gap
   localparam int DRAIN_CYCLES   = 64;    // longer than the slowest item

   // Code 7 has no operation behind it; the block must answer it and change nothing.
   localparam logic [plt_pkg::FUNC_W-1:0] FN_UNDEFINED = 3'd7;

   // Stimulus moods: grow the table, shrink it, or a flat mix.
   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   localparam logic signed [plt_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [plt_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic [plt_pkg::FUNC_W-1:0]         req_func     = '0;
   logic [plt_pkg::POS_W-1:0]          req_position = '0;
   logic signed [plt_pkg::VALUE_W-1:0] req_value    = '0;
   logic                               rsp_strobe;
   logic                               rsp_ok;
   logic signed [plt_pkg::VALUE_W-1:0] rsp_read_value;
   logic [plt_pkg::INDEX_W-1:0]        rsp_found_index;
   logic [plt_pkg::ENTRY_W-1:0]        rsp_entry_count;

   int fail_count;
   int pending;
   int fill_level;
   int unsigned quiet_cycles = 0;

   // Recently written values; searches and replaces draw on them to get hits and duplicates.
   logic signed [plt_pkg::VALUE_W-1:0] recent_values [8] = '{default: '0};

   // Operation order and cumulative weights (out of 100) for each mood.
   logic [plt_pkg::FUNC_W-1:0] func_order [8] = '{plt_pkg::FN_INSERT, plt_pkg::FN_SORTED,
                                                 plt_pkg::FN_READ, plt_pkg::FN_REPLACE,
                                                 plt_pkg::FN_REMOVE, plt_pkg::FN_SEARCH,
                                                 plt_pkg::FN_REVERSE, FN_UNDEFINED};
   int unsigned func_weights [3][8] = '{'{30, 50, 60, 67, 74, 87, 97, 100},
                                        '{10, 18, 30, 38, 75, 89, 98, 100},
                                        '{15, 29, 43, 57, 71, 85, 98, 100}};

   always #5 clock = ~clock;

   positional_list_table dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_ok          (rsp_ok),
      .rsp_read_value  (rsp_read_value),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count)
   );

   list_table_checker table_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_ok          (rsp_ok),
      .rsp_read_value  (rsp_read_value),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count),
      .fail_count      (fail_count),
      .pending         (pending),
      .fill_level      (fill_level)
   );

   // Watchdog: any cycle with an accepted item or a strobed result counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one item at a falling edge and hold it until the block takes it.
   // Returns at the falling edge after acceptance with start still high, so a
   // back-to-back item never sees start dip.
   task automatic issue(logic [plt_pkg::FUNC_W-1:0] func, logic [plt_pkg::POS_W-1:0] position,
                        logic signed [plt_pkg::VALUE_W-1:0] value);
      start        = 1'b1;
      req_func     = func;
      req_position = position;
      req_value    = value;
      // busy only moves on a rising edge, so its level here holds for the coming edge.
      while (busy)
         @(negedge clock);
      @(posedge clock);
      @(negedge clock);
      if (func == plt_pkg::FN_INSERT || func == plt_pkg::FN_SORTED ||
          func == plt_pkg::FN_REPLACE)
         recent_values[$urandom_range(0, 7)] = value;
   endtask

   // Drop start for a number of cycles and put noise on the request fields meanwhile.
   task automatic pause(int unsigned cycles);
      if (cycles > 0) begin
         start        = 1'b0;
         req_func     = plt_pkg::FUNC_W'($urandom);
         req_position = plt_pkg::POS_W'($urandom);
         req_value    = $urandom;
         repeat (cycles) @(negedge clock);
      end
   endtask

   function automatic logic signed [plt_pkg::VALUE_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 25)
         return int'($urandom_range(0, 8)) - 4;
      if (r < 35) begin
         case ($urandom_range(0, 3))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return '0;
            default: return -1;
         endcase
      end
      if (r < 60)
         return recent_values[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // Mostly in range for the current fill, with the edges and wild positions mixed in.
   function automatic logic [plt_pkg::POS_W-1:0] pick_position(int level);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return plt_pkg::POS_W'($urandom_range(0, level));
      if (r < 80) return plt_pkg::POS_W'(level);
      if (r < 88) return plt_pkg::POS_W'(level + 1);
      return plt_pkg::POS_W'($urandom_range(0, 31));
   endfunction

   function automatic logic [plt_pkg::FUNC_W-1:0] pick_func(int mode);
      int unsigned r;
      r = $urandom_range(0, 99);
      for (int k = 0; k < 8; k++)
         if (r < func_weights[mode][k])
            return func_order[k];
      return FN_UNDEFINED;
   endfunction

   initial begin
      int          mode;
      bit          steady;
      int unsigned r;

      mode   = MODE_FILL;
      steady = 1'b0;

      // Hold reset, then release it away from the sampling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty table: every positional access fails, reverse still succeeds.
      issue(plt_pkg::FN_REVERSE, 5'd0, 32'sd0);
      issue(plt_pkg::FN_READ, 5'd0, 32'sd0);
      issue(plt_pkg::FN_REMOVE, 5'd0, 32'sd0);
      issue(plt_pkg::FN_REPLACE, 5'd0, 32'sd9);
      issue(plt_pkg::FN_SEARCH, 5'd0, 32'sd0);
      // Insert beyond the count is rejected.
      issue(plt_pkg::FN_INSERT, 5'd1, 32'sd1);
      // Insert at the front keeps the old entries; then append, then mid-table.
      issue(plt_pkg::FN_INSERT, 5'd0, VALUE_MIN);
      issue(plt_pkg::FN_INSERT, 5'd0, VALUE_MAX);
      issue(plt_pkg::FN_INSERT, 5'd2, 32'sd0);
      issue(plt_pkg::FN_INSERT, 5'd1, -32'sd1);
      issue(plt_pkg::FN_READ, 5'd3, 32'sd0);
      issue(plt_pkg::FN_READ, 5'd31, 32'sd0);
      // Search hit and miss.
      issue(plt_pkg::FN_SEARCH, 5'd0, VALUE_MIN);
      issue(plt_pkg::FN_SEARCH, 5'd0, 32'sd5);
      // Sorted insert of a value equal to an entry, then reverse an odd count.
      issue(plt_pkg::FN_SORTED, 5'd0, 32'sd0);
      issue(plt_pkg::FN_REVERSE, 5'd0, 32'sd0);
      // Duplicate value: search must report the lowest index.
      issue(plt_pkg::FN_REPLACE, 5'd4, -32'sd1);
      issue(plt_pkg::FN_SEARCH, 5'd0, -32'sd1);
      // Remove at the count is rejected; remove the last and the first entry.
      issue(plt_pkg::FN_REMOVE, 5'd5, 32'sd0);
      issue(plt_pkg::FN_REMOVE, 5'd4, 32'sd0);
      issue(plt_pkg::FN_REMOVE, 5'd0, 32'sd0);
      issue(FN_UNDEFINED, 5'd0, 32'sd3);
      issue(plt_pkg::FN_SORTED, 5'd0, VALUE_MIN);
      issue(plt_pkg::FN_SORTED, 5'd0, VALUE_MAX);

      // Random part: swing the table between empty and full so that full-table
      // rejects and long shifts are hit often, with random gaps in between.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         issue(pick_func(mode), pick_position(fill_level), pick_value());

         if (fill_level == plt_pkg::DEPTH && $urandom_range(0, 3) == 0)
            mode = MODE_DRAIN;
         else if (fill_level == 0 && $urandom_range(0, 3) == 0)
            mode = MODE_FILL;
         else if ($urandom_range(0, 99) == 0)
            mode = $urandom_range(MODE_FILL, MODE_MIXED);

         // Alternate stretches of back-to-back items with gappy stretches.
         if ($urandom_range(0, 59) == 0)
            steady = !steady;
         if (!steady) begin
            r = $urandom_range(0, 99);
            if (r < 60)
               pause(0);
            else if (r < 93)
               pause($urandom_range(1, 4));
            else
               pause($urandom_range(10, 40));
         end
      end

      // Drain: wait for every outstanding result, then give the block time to
      // show anything stray.
      pause(1);
      while (pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
